// ===== design/soc_pkg.sv =====
// Shared types and constants for the substring occurrence counter.
package soc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int LEN_W       = 5;
  localparam int INDEX_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 32;

  localparam logic OP_PAT_WRITE = 1'b0;
  localparam logic OP_TEXT_BYTE = 1'b1;

  typedef enum logic [1:0] {
    CMD_PAT_WRITE  = 2'd0,
    CMD_PAT_IGNORE = 2'd1,
    CMD_TEXT_BYTE  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  byte_value;
    logic               first;
  } cmd_t;

  typedef struct packed {
    logic               match;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ===== design/soc_front.sv =====
// Input side: accepts beats, classifies them and queues the commands.
module soc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_op,
  input  logic [soc_pkg::INDEX_W-1:0] in_index,
  input  logic [soc_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                        in_first,
  output logic                        cmd_valid,
  output soc_pkg::cmd_t               cmd,
  input  logic                        cmd_ready
);
  import soc_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cmd_in.index      = in_index;
    cmd_in.byte_value = in_byte_value;
    cmd_in.first      = 1'b0;
    if (in_op == OP_TEXT_BYTE) begin
      cmd_in.kind  = CMD_TEXT_BYTE;
      cmd_in.first = in_first;
    end else if (int'(in_index) < MAX_PATTERN) begin
      cmd_in.kind = CMD_PAT_WRITE;
    end else begin
      cmd_in.kind = CMD_PAT_IGNORE;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign do_pop    = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== design/soc_back.sv =====
// Execution side: pattern store, text window, compare, count and result queue.
module soc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [soc_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                        cmd_valid,
  input  soc_pkg::cmd_t               cmd,
  output logic                        cmd_ready,
  output logic                        empty,
  input  logic                        pop,
  output soc_pkg::result_t            res
);
  import soc_pkg::*;

  logic [BYTE_W-1:0]  pat_r [MAX_PATTERN];
  logic [BYTE_W-1:0]  win_r [MAX_PATTERN];
  logic [BYTE_W-1:0]  win_nxt [MAX_PATTERN];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0]   len_r;
  logic               hit;
  logic               step;
  result_t            res_in;

  result_t    oq_r [2];
  logic       owr_r, owr_nxt;
  logic       ord_r, ord_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       do_pop;

  assign cmd_ready = (ocnt_r != 2'd2);
  assign step      = cmd_valid && cmd_ready;

  always_comb begin
    logic [FILL_W-1:0] fill_base;
    logic [LEN_W-1:0]  tidx;
    logic              eq;
    win_nxt[0] = cmd.byte_value;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    fill_base = cmd.first ? '0 : fill_r;
    fill_nxt  = (int'(fill_base) < MAX_PATTERN) ? fill_base + FILL_W'(1) : fill_base;
    eq = (len_r != '0) && (int'(len_r) <= MAX_PATTERN) && (int'(fill_nxt) >= int'(len_r));
    for (int j = 0; j < MAX_PATTERN; j++) begin
      tidx = LEN_W'(int'(len_r) - 1 - j);
      if ((j < int'(len_r)) && (pat_r[j] != win_nxt[tidx[WIN_IDX_W-1:0]])) begin
        eq = 1'b0;
      end
    end
    hit       = eq;
    count_nxt = cmd.first ? '0 : count_r;
    if (hit && (count_nxt != '1)) begin
      count_nxt = count_nxt + COUNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_TEXT_BYTE: begin
        res_in.match = hit;
        res_in.count = count_nxt;
      end
      default: begin
        res_in.match = 1'b0;
        res_in.count = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat_r[i] <= '0;
        win_r[i] <= '0;
      end
      fill_r  <= '0;
      count_r <= '0;
      len_r   <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (step) begin
        unique case (cmd.kind)
          CMD_PAT_WRITE: begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
              if (int'(cmd.index) == i) begin
                pat_r[i] <= cmd.byte_value;
              end
            end
          end
          CMD_TEXT_BYTE: begin
            win_r   <= win_nxt;
            fill_r  <= fill_nxt;
            count_r <= count_nxt;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign empty  = (ocnt_r == 2'd0);
  assign do_pop = pop && !empty;
  assign res    = oq_r[ord_r];

  always_comb begin
    owr_nxt  = step ? ~owr_r : owr_r;
    ord_nxt  = do_pop ? ~ord_r : ord_r;
    ocnt_nxt = ocnt_r + {1'b0, step} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      oq_r[owr_r] <= res_in;
    end
  end

endmodule

// ===== design/substring_occurrence_counter_core.sv =====
// Top level of the substring occurrence counter.
// Counts overlapping occurrences of a stored pattern of up to 16 bytes in a stream
// of text bytes. A beat with op 0 writes one pattern byte, a beat with op 1 shifts
// one text byte into the window; first on a text beat clears the window fill and the
// count. Every beat yields one result beat with a match flag and the saturating count.
// A pattern length of 0 or above 16 never matches. Both sides are two-entry queues,
// and the window compare runs in the same cycle in which a command leaves the input
// queue, so the block sustains one beat per clock while the result queue is not full.
// pattern_length must be written only while the block is idle.
module substring_occurrence_counter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [soc_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_op,
  input  logic [soc_pkg::INDEX_W-1:0] in_index,
  input  logic [soc_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                        in_first,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_match,
  output logic [soc_pkg::COUNT_W-1:0] out_count
);
  import soc_pkg::*;

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t res;

  soc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_byte_value (in_byte_value),
    .in_first      (in_first),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready)
  );

  soc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_match = res.match;
  assign out_count = res.count;

endmodule

// ===== verif/substring_occurrence_counter_core_test.sv =====
// Testbench for the substring occurrence counter: random pattern sessions checked against a predictor.
`timescale 1ns / 100ps

module substring_occurrence_counter_core_test;
  import soc_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int PRINT_LIMIT  = 200;

  class occurrence_scoreboard;
    logic [BYTE_W-1:0]  pattern_bytes [MAX_PATTERN];
    logic [BYTE_W-1:0]  window_bytes [MAX_PATTERN];
    int unsigned        window_fill;
    logic [COUNT_W-1:0] occurrences;
    logic [LEN_W-1:0]   pattern_len;
    result_t            expected_counts [$];
    int unsigned        mismatch_count;

    function new();
      foreach (pattern_bytes[i]) begin
        pattern_bytes[i] = '0;
        window_bytes[i]  = '0;
      end
      window_fill    = 0;
      occurrences    = '0;
      pattern_len    = '0;
      mismatch_count = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
      pattern_len = value;
    endfunction

    function bit window_hit();
      if (pattern_len == 0 || pattern_len > MAX_PATTERN || window_fill < pattern_len) begin
        return 1'b0;
      end
      for (int j = 0; j < pattern_len; j++) begin
        if (pattern_bytes[j] != window_bytes[pattern_len - 1 - j]) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void predict_occurrence(logic op, logic [INDEX_W-1:0] idx,
                                     logic [BYTE_W-1:0] value, logic first_flag);
      result_t exp;
      exp.match = 1'b0;
      if (op == OP_PAT_WRITE) begin
        if (idx < MAX_PATTERN) begin
          pattern_bytes[idx] = value;
        end
      end else begin
        if (first_flag) begin
          window_fill = 0;
          occurrences = '0;
        end
        for (int i = MAX_PATTERN - 1; i > 0; i--) begin
          window_bytes[i] = window_bytes[i-1];
        end
        window_bytes[0] = value;
        if (window_fill < MAX_PATTERN) begin
          window_fill++;
        end
        if (window_hit()) begin
          exp.match = 1'b1;
          if (occurrences != '1) begin
            occurrences++;
          end
        end
      end
      exp.count = occurrences;
      expected_counts.push_back(exp);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    task check_occurrence(logic hit, logic [COUNT_W-1:0] cnt);
      result_t exp;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected beat match=%0b count=%0d", hit, cnt));
        return;
      end
      exp = expected_counts.pop_front();
      if (hit !== exp.match) begin
        report_mismatch($sformatf("match %0b, expected %0b", hit, exp.match));
      end
      if (cnt !== exp.count) begin
        report_mismatch($sformatf("count %0d, expected %0d", cnt, exp.count));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [LEN_W-1:0]    cfg_wdata     = '0;
  logic                push          = 1'b0;
  logic                full;
  logic                in_op         = OP_PAT_WRITE;
  logic [INDEX_W-1:0]  in_index      = '0;
  logic [BYTE_W-1:0]   in_byte_value = '0;
  logic                in_first      = 1'b0;
  logic                empty;
  logic                pop           = 1'b0;
  logic                out_match;
  logic [COUNT_W-1:0]  out_count;

  occurrence_scoreboard sb = new();

  int unsigned         sender_idle_pct   = 13;
  int unsigned         receiver_idle_pct = 80;
  int unsigned         items_sent        = 0;
  logic [BYTE_W-1:0]   sym_a;
  logic [BYTE_W-1:0]   sym_b;
  logic                next_first;

  substring_occurrence_counter_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_byte_value (in_byte_value),
    .in_first      (in_first),
    .empty         (empty),
    .pop           (pop),
    .out_match     (out_match),
    .out_count     (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.set_length(cfg_wdata);
      end
      if (push && !full) begin
        sb.predict_occurrence(in_op, in_index, in_byte_value, in_first);
      end
      if (pop && !empty) begin
        sb.check_occurrence(out_match, out_count);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      pop <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] value,
                           logic first_flag);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    in_op         <= op;
    in_index      <= idx;
    in_byte_value <= value;
    in_first      <= first_flag;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_text(logic [BYTE_W-1:0] value);
    send_item(OP_TEXT_BYTE, INDEX_W'($urandom_range(15)), value, next_first);
    next_first = 1'b0;
  endtask

  task automatic write_length(int unsigned value);
    @(negedge clk) push <= 1'b0;
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_wdata <= LEN_W'(value);
    cfg_we    <= 1'b1;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_symbol();
    if ($urandom_range(19) == 0) begin
      return BYTE_W'($urandom_range(255));
    end
    return $urandom_range(1) ? sym_a : sym_b;
  endfunction

  task automatic run_session(int unsigned len, int unsigned n_text);
    int unsigned span;
    int unsigned start;
    int unsigned plen;
    write_length(len);
    sym_a = BYTE_W'($urandom_range(255));
    sym_b = BYTE_W'($urandom_range(255));
    span  = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    for (int k = 0; k < span; k++) begin
      send_item(OP_PAT_WRITE, INDEX_W'(k), pick_symbol(), 1'($urandom_range(1)));
    end
    if ($urandom_range(3) == 0) begin
      send_item(OP_PAT_WRITE, INDEX_W'($urandom_range(15)), pick_symbol(),
                1'($urandom_range(1)));
    end
    next_first = ($urandom_range(3) != 0);
    start      = items_sent;
    while (items_sent - start < n_text) begin
      case ($urandom_range(19))
        0: begin
          send_item(OP_PAT_WRITE, INDEX_W'($urandom_range(15)), pick_symbol(),
                    1'($urandom_range(1)));
        end
        1: begin
          next_first = 1'b1;
          send_text(pick_symbol());
        end
        2: begin
          send_text(BYTE_W'($urandom_range(255)));
        end
        3, 4, 5, 6, 7, 8: begin
          send_text(pick_symbol());
        end
        default: begin
          if (span == 0) begin
            send_text(pick_symbol());
          end else begin
            plen = $urandom_range(2) == 0 ? $urandom_range(1, span) : span;
            for (int k = 0; k < plen; k++) begin
              send_text(sb.pattern_bytes[k]);
            end
          end
        end
      endcase
    end
  endtask

  initial begin
    int unsigned directed_items;
    int unsigned progress;
    int unsigned len;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_length(0);
    send_item(OP_TEXT_BYTE, 4'd0, 8'h00, 1'b1);
    write_length(1);
    send_item(OP_TEXT_BYTE, 4'd15, 8'h00, 1'b0);
    send_item(OP_PAT_WRITE, 4'd0, 8'hFF, 1'b1);
    send_item(OP_TEXT_BYTE, 4'd0, 8'hFF, 1'b0);
    send_item(OP_TEXT_BYTE, 4'd0, 8'hFF, 1'b0);
    send_item(OP_PAT_WRITE, 4'd15, 8'hA5, 1'b0);
    write_length(2);
    send_item(OP_TEXT_BYTE, 4'd0, 8'hFF, 1'b1);
    send_item(OP_TEXT_BYTE, 4'd0, 8'h00, 1'b0);
    write_length(MAX_PATTERN);
    send_item(OP_TEXT_BYTE, 4'd0, 8'hFF, 1'b1);
    repeat (MAX_PATTERN - 2) send_item(OP_TEXT_BYTE, 4'd0, 8'h00, 1'b0);
    send_item(OP_TEXT_BYTE, 4'd0, 8'hA5, 1'b0);
    write_length(MAX_PATTERN + 1);
    send_item(OP_TEXT_BYTE, 4'd0, 8'h00, 1'b0);

    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      progress = items_sent - directed_items;
      if (progress < RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 13;
        receiver_idle_pct = 80;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 80;
        receiver_idle_pct = 13;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: len = 0;
        1: len = MAX_PATTERN;
        2: len = MAX_PATTERN + 1;
        3: len = (1 << LEN_W) - 1;
        4: len = $urandom_range(MAX_PATTERN + 2, (1 << LEN_W) - 2);
        5: len = $urandom_range(7, MAX_PATTERN);
        default: len = $urandom_range(1, 6);
      endcase
      run_session(len, $urandom_range(10, 60));
    end

    @(negedge clk) push <= 1'b0;
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
